// ===== src/sui_pkg.sv =====
package sui_pkg;

    // fixed field widths
    localparam int STATE_W  = 6;
    localparam int CNT_W    = 7;
    localparam int SUBSET_W = 64;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 7;
    localparam int S_DATA_W = 80;
    localparam int M_DATA_W = 64;

    // opcodes
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_APPLY = 1'b1;

    // directions
    localparam logic DIR_IMAGE    = 1'b0;
    localparam logic DIR_PREIMAGE = 1'b1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DIRECTION     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STATES_IN_USE = 2'd1;

    localparam logic [CNT_W-1:0] STATES_RESET = 7'd64;

    typedef struct packed {
        logic             dir;
        logic [CNT_W-1:0] base;
        logic [CNT_W-1:0] count;
    } slice_ctl_t;

endpackage

// ===== src/sui_map_mem.sv =====
module sui_map_mem
    import sui_pkg::*;
#(
    parameter int ROWS  = 16,
    parameter int ROW_W = 4,
    parameter int LANES = 8,
    parameter int LANE_W = 3
)
(
    input  logic                       clk,
    input  logic                       wr_en,
    input  logic [ROW_W-1:0]           wr_row,
    input  logic [LANE_W-1:0]          wr_lane,
    input  logic [STATE_W-1:0]         wr_data,
    input  logic                       rd_en,
    input  logic [ROW_W-1:0]           rd_row,
    output logic [LANES*STATE_W-1:0]   rd_data
);

    logic [LANES*STATE_W-1:0] mem [ROWS];

    // one entry of a row written per load
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_row][wr_lane*STATE_W +: STATE_W] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_row];
        end
    end

endmodule

// ===== src/sui_slice_unit.sv =====
module sui_slice_unit
    import sui_pkg::*;
#(
    parameter int SLICE_BITS = 8
)
(
    input  logic [SLICE_BITS*STATE_W-1:0] row_data,
    input  slice_ctl_t                    ctl,
    input  logic [SUBSET_W-1:0]           subset,
    output logic [SUBSET_W-1:0]           contrib
);

    // each lane handles state base+j of the slice
    always_comb
    begin : lanes
        logic [CNT_W-1:0]   n;
        logic [STATE_W-1:0] t;
        contrib = '0;
        for (int j = 0; j < SLICE_BITS; j++)
        begin
            n = ctl.base + CNT_W'(j);
            t = row_data[j*STATE_W +: STATE_W];
            if (n < ctl.count)
            begin
                if (ctl.dir == DIR_IMAGE)
                begin
                    if (subset[n[STATE_W-1:0]])
                    begin
                        contrib[t] = 1'b1;
                    end
                end
                else if (subset[t])
                begin
                    contrib[n[STATE_W-1:0]] = 1'b1;
                end
            end
        end
    end

endmodule

// ===== src/subset_image_under_letter_top.sv =====
// channel  | direction | signals                          | word
// s_*      | in        | s_tvalid s_tready s_tdata s_tuser s_tlast | load or apply item
// m_*      | out       | m_tvalid m_tready m_tdata m_tlast | image/preimage subset
// cfg_*    | in        | cfg_valid cfg_ready cfg_index cfg_data | register write
//
// A load word writes one map entry when it is taken.
// An apply word is worked in S_RUN, one slice of states per cycle: each slice is read
// from the map memory and accumulated; in S_OUT the result goes to the output register.
// s_tready is low from the cycle after an apply word is taken until its result is
// registered; a result still waiting in the output register holds the next one back.
// rst_n clears control and config; the map memory is not cleared.
module subset_image_under_letter_top
    import sui_pkg::*;
#(
    parameter int NUM_STATES  = 64,
    parameter int NUM_LETTERS = 2,
    parameter int SLICE_BITS  = 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // letter[0], source_state[6:1], target_state[12:7], subset_in[76:13], zeros above
    input  logic [S_DATA_W-1:0]   s_tdata,
    // opcode[0]
    input  logic                  s_tuser,
    input  logic                  s_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // subset_out[63:0]
    output logic [M_DATA_W-1:0]   m_tdata,
    output logic                  m_tlast,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DAT_W-1:0]  cfg_data
);

    localparam int SLICES = (NUM_STATES + SLICE_BITS - 1) / SLICE_BITS;
    localparam int ROWS   = NUM_LETTERS * SLICES;
    localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int SLC_W  = $clog2(SLICES + 1);
    localparam int LANE_W = (SLICE_BITS > 1) ? $clog2(SLICE_BITS) : 1;
    localparam int NUM_SRC = 1 << STATE_W;
    localparam logic [ROW_W-1:0] LETTER1_BASE = ROW_W'(SLICES);
    localparam logic [CNT_W-1:0] MAX_COUNT    = CNT_W'(NUM_STATES);
    localparam logic [CNT_W-1:0] SLICE_STEP   = CNT_W'(SLICE_BITS);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_OUT  = 2'd2;

    logic [1:0]             state_reg, state_next;
    logic                   direction_reg;
    logic [CNT_W-1:0]       states_reg;
    logic                   letter_reg, letter_next;
    logic                   last_reg, last_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [SUBSET_W-1:0]    subset_reg, subset_next;
    logic [SUBSET_W-1:0]    mask_reg, mask_next;
    logic [SUBSET_W-1:0]    acc_reg, acc_next;
    logic [CNT_W-1:0]       issue_base_reg, issue_base_next;
    logic [SLC_W-1:0]       slice_reg, slice_next;
    logic                   pend_reg, pend_next;
    logic [CNT_W-1:0]       pend_base_reg, pend_base_next;
    logic                   m_valid_reg, m_valid_next;
    logic [M_DATA_W-1:0]    m_data_reg, m_data_next;
    logic                   m_last_reg, m_last_next;

    logic                   in_letter;
    logic [STATE_W-1:0]     in_src;
    logic [STATE_W-1:0]     in_dst;
    logic [SUBSET_W-1:0]    in_subset;
    logic                   s_fire;
    logic                   letter_ok;
    logic [CNT_W-1:0]       sat_count;
    logic [SUBSET_W-1:0]    new_mask;
    logic                   issue_ok;

    logic                   wr_en;
    logic [ROW_W-1:0]       wr_row;
    logic                   rd_en;
    logic [ROW_W-1:0]       rd_row;
    logic [SLICE_BITS*STATE_W-1:0] rd_data;
    slice_ctl_t             ctl;
    logic [SUBSET_W-1:0]    contrib;

    logic [SLC_W-1:0]       slice_of [NUM_SRC];
    logic [LANE_W-1:0]      lane_of  [NUM_SRC];

    // constant lookup: slice and lane of every source state
    for (genvar g = 0; g < NUM_SRC; g++)
    begin : g_lut
        assign slice_of[g] = SLC_W'(g / SLICE_BITS);
        assign lane_of[g]  = LANE_W'(g % SLICE_BITS);
    end

    assign in_letter = s_tdata[0];
    assign in_src    = s_tdata[6:1];
    assign in_dst    = s_tdata[12:7];
    assign in_subset = s_tdata[76:13];

    assign s_tready  = (state_reg == S_IDLE);
    assign s_fire    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign letter_ok = (NUM_LETTERS > 1) || (in_letter == 1'b0);
    assign sat_count = (states_reg > MAX_COUNT) ? MAX_COUNT : states_reg;
    // shift by 64 leaves zero, so a full count gives all ones
    assign new_mask  = ~({SUBSET_W{1'b1}} << (letter_ok ? sat_count : '0));

    assign wr_en  = s_fire && (s_tuser == OP_LOAD) && letter_ok
                    && ({1'b0, in_src} < MAX_COUNT) && ({1'b0, in_dst} < MAX_COUNT);
    assign wr_row = (in_letter ? LETTER1_BASE : '0) + ROW_W'(slice_of[in_src]);

    assign issue_ok = (state_reg == S_RUN) && (issue_base_reg < count_reg);
    assign rd_en    = issue_ok;
    assign rd_row   = (letter_reg ? LETTER1_BASE : '0) + ROW_W'(slice_reg);

    assign ctl.dir   = direction_reg;
    assign ctl.base  = pend_base_reg;
    assign ctl.count = count_reg;

    sui_map_mem #(
        .ROWS   (ROWS),
        .ROW_W  (ROW_W),
        .LANES  (SLICE_BITS),
        .LANE_W (LANE_W)
    ) u_map (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_row  (wr_row),
        .wr_lane (lane_of[in_src]),
        .wr_data (in_dst),
        .rd_en   (rd_en),
        .rd_row  (rd_row),
        .rd_data (rd_data)
    );

    sui_slice_unit #(
        .SLICE_BITS (SLICE_BITS)
    ) u_slice (
        .row_data (rd_data),
        .ctl      (ctl),
        .subset   (subset_reg),
        .contrib  (contrib)
    );

    always_comb
    begin
        state_next      = state_reg;
        letter_next     = letter_reg;
        last_next       = last_reg;
        count_next      = count_reg;
        subset_next     = subset_reg;
        mask_next       = mask_reg;
        acc_next        = acc_reg;
        issue_base_next = issue_base_reg;
        slice_next      = slice_reg;
        pend_next       = 1'b0;
        pend_base_next  = pend_base_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_data_next     = m_data_reg;
        m_last_next     = m_last_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_fire && (s_tuser == OP_APPLY))
                begin
                    letter_next     = in_letter;
                    last_next       = s_tlast;
                    count_next      = letter_ok ? sat_count : '0;
                    mask_next       = new_mask;
                    subset_next     = in_subset & new_mask;
                    acc_next        = '0;
                    issue_base_next = '0;
                    slice_next      = '0;
                    state_next      = S_RUN;
                end
            end
            S_RUN:
            begin
                if (pend_reg)
                begin
                    acc_next = acc_reg | contrib;
                end
                if (issue_ok)
                begin
                    pend_next       = 1'b1;
                    pend_base_next  = issue_base_reg;
                    issue_base_next = issue_base_reg + SLICE_STEP;
                    slice_next      = slice_reg + SLC_W'(1);
                end
                else if (!pend_reg)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = acc_reg & mask_reg;
                    m_last_next  = last_reg;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pend_reg      <= 1'b0;
            m_valid_reg   <= 1'b0;
            direction_reg <= DIR_IMAGE;
            states_reg    <= STATES_RESET;
        end
        else
        begin
            state_reg   <= state_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_DIRECTION:     direction_reg <= cfg_data[0];
                    REG_STATES_IN_USE: states_reg    <= cfg_data;
                    default:           ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        letter_reg     <= letter_next;
        last_reg       <= last_next;
        count_reg      <= count_next;
        subset_reg     <= subset_next;
        mask_reg       <= mask_next;
        acc_reg        <= acc_next;
        issue_base_reg <= issue_base_next;
        slice_reg      <= slice_next;
        pend_base_reg  <= pend_base_next;
        m_data_reg     <= m_data_next;
        m_last_reg     <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

endmodule

// ===== verif/subset_image_checker.sv =====
module subset_image_checker
    import sui_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    // letter[0], source_state[6:1], target_state[12:7], subset_in[76:13], zeros above
    input  logic [S_DATA_W-1:0]  s_tdata,
    // opcode[0]
    input  logic                 s_tuser,
    input  logic                 s_tlast,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    // subset_out[63:0]
    input  logic [M_DATA_W-1:0]  m_tdata,
    input  logic                 m_tlast,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data,
    output int                   mismatches,
    output int                   outstanding,
    output int                   compared
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [SUBSET_W-1:0] subset;
        logic                last;
    } image_word_t;

    logic [STATE_W-1:0] trans_map [0:2*SUBSET_W-1];
    logic               dir_mode;
    logic [CNT_W-1:0]   live_states;
    image_word_t        pending_images [$];

    initial
    begin
        mismatches  = 0;
        outstanding = 0;
        compared    = 0;
        dir_mode    = DIR_IMAGE;
        live_states = STATES_RESET;
    end

    function automatic logic [SUBSET_W-1:0] image_of_subset(input logic ltr,
                                                             input logic [SUBSET_W-1:0] members);
        int                  cnt;
        logic [SUBSET_W-1:0] keep;
        logic [SUBSET_W-1:0] img;
        logic [STATE_W-1:0]  tgt;
        cnt  = (live_states > SUBSET_W) ? SUBSET_W : int'(live_states);
        keep = (cnt >= SUBSET_W) ? '1 : ((64'd1 << cnt) - 64'd1);
        img  = '0;
        members = members & keep;
        for (int n = 0; n < cnt; n++)
        begin
            tgt = trans_map[int'(ltr) * SUBSET_W + n];
            if (dir_mode == DIR_IMAGE)
            begin
                if (members[n])
                    img[tgt] = 1'b1;
            end
            else if (members[tgt])
                img[n] = 1'b1;
        end
        return img & keep;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        image_word_t want;
        if (!rst_n)
        begin
            dir_mode    = DIR_IMAGE;
            live_states = STATES_RESET;
            pending_images.delete();
            outstanding = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_DIRECTION)
                    dir_mode = cfg_data[0];
                else if (cfg_index == REG_STATES_IN_USE)
                    live_states = cfg_data;
            end
            if (m_tvalid && m_tready)
            begin
                if (pending_images.size() == 0)
                begin
                    $display("%0t: unexpected result word: expected none, got subset %h last %b",
                             $time, m_tdata, m_tlast);
                    mismatches++;
                end
                else
                begin
                    want = pending_images.pop_front();
                    compared++;
                    if (m_tdata !== want.subset)
                    begin
                        $display("%0t: subset_out mismatch: expected %h, got %h",
                                 $time, want.subset, m_tdata);
                        mismatches++;
                    end
                    if (m_tlast !== want.last)
                    begin
                        $display("%0t: last_out mismatch: expected %b, got %b",
                                 $time, want.last, m_tlast);
                        mismatches++;
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                if (s_tuser == OP_LOAD)
                    trans_map[int'(s_tdata[0]) * SUBSET_W + int'(s_tdata[6:1])] = s_tdata[12:7];
                else
                begin
                    want.subset = image_of_subset(s_tdata[0], s_tdata[76:13]);
                    want.last   = s_tlast;
                    pending_images.push_back(want);
                end
            end
            outstanding = pending_images.size();
        end
    end

endmodule

// ===== verif/subset_image_under_letter_top_tb.sv =====
module subset_image_under_letter_top_tb
    import sui_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_PHASES  = 12;
    localparam int PHASE_ITEMS = 150;
    localparam int STALL_LIMIT = 2000;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_DATA_W-1:0]  s_tdata = '0;
    logic                 s_tuser = 1'b0;
    logic                 s_tlast = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_DATA_W-1:0]  m_tdata;
    logic                 m_tlast;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DAT_W-1:0] cfg_data = '0;

    int mismatches;
    int outstanding;
    int compared;
    int loads_sent = 0;
    int applies_sent = 0;
    int settings_done = 0;
    int stuck_cycles = 0;
    bit no_idle = 1'b0;
    bit written [0:2*SUBSET_W-1];

    always #5 clk = ~clk;

    subset_image_under_letter_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    subset_image_checker image_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding),
        .compared    (compared)
    );

    always @(negedge clk)
        m_tready <= no_idle || ($urandom_range(99) >= 6);

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no word moved for %0d cycles", $time, stuck_cycles);
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic send_word(input logic op, input logic ltr, input logic [STATE_W-1:0] src,
                             input logic [STATE_W-1:0] tgt, input logic [SUBSET_W-1:0] members,
                             input logic last);
        @(negedge clk);
        while (!no_idle && $urandom_range(99) < 6)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tlast  <= last;
        s_tdata  <= {3'b000, members, tgt, src, ltr};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // subset and last ride along with loads as noise; the block must ignore them
    task automatic load_entry(input logic ltr, input logic [STATE_W-1:0] src,
                              input logic [STATE_W-1:0] tgt);
        send_word(OP_LOAD, ltr, src, tgt, {$urandom, $urandom}, 1'($urandom_range(1)));
        written[int'(ltr) * SUBSET_W + int'(src)] = 1'b1;
        loads_sent++;
    endtask

    task automatic apply_subset(input logic ltr, input logic [SUBSET_W-1:0] members,
                                input logic last);
        send_word(OP_APPLY, ltr, 6'($urandom_range(63)), 6'($urandom_range(63)), members, last);
        applies_sent++;
    endtask

    // hold off the sender until every expected result is out
    task automatic drain_results();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (16) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // new setting, then make sure every entry an apply may read has been loaded
    task automatic configure(input logic dirv, input logic [CNT_W-1:0] cnt);
        int lim;
        drain_results();
        write_reg(REG_DIRECTION, {6'b0, dirv});
        write_reg(REG_STATES_IN_USE, cnt);
        settings_done++;
        lim = (cnt > SUBSET_W) ? SUBSET_W : int'(cnt);
        for (int l = 0; l < 2; l++)
            for (int s = 0; s < lim; s++)
                if (!written[l * SUBSET_W + s])
                    load_entry(1'(l), 6'(s), 6'($urandom_range(63)));
    endtask

    function automatic logic [SUBSET_W-1:0] random_subset();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            2: return 64'd1 << $urandom_range(63);
            3, 4: return {$urandom, $urandom} & {$urandom, $urandom};
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [CNT_W-1:0] phase_count(input int p);
        case (p)
            0, 1: return 7'd8;
            2, 3: return 7'd1;
            4, 5: return 7'd64;
            6, 7: return 7'd127;
            8: return 7'd0;
            9: return 7'd37;
            10: return 7'd23;
            default: return 7'd100;
        endcase
    endfunction

    initial
    begin
        for (int i = 0; i < 2 * SUBSET_W; i++)
            written[i] = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // four states; targets at and above the count, a load far above it
        write_reg(REG_STATES_IN_USE, 7'd4);
        load_entry(1'b0, 6'd0, 6'd0);
        load_entry(1'b0, 6'd1, 6'd63);
        load_entry(1'b0, 6'd2, 6'd3);
        load_entry(1'b0, 6'd3, 6'd2);
        load_entry(1'b1, 6'd0, 6'd1);
        load_entry(1'b1, 6'd1, 6'd1);
        load_entry(1'b1, 6'd2, 6'd5);
        load_entry(1'b1, 6'd3, 6'd0);
        load_entry(1'b1, 6'd63, 6'd63);
        apply_subset(1'b0, '1, 1'b1);
        apply_subset(1'b0, '0, 1'b0);
        apply_subset(1'b0, 64'h8000_0000_0000_0000, 1'b1);
        apply_subset(1'b1, 64'h5, 1'b0);
        apply_subset(1'b1, '1, 1'b1);

        configure(DIR_PREIMAGE, 7'd4);
        apply_subset(1'b0, '1, 1'b0);
        apply_subset(1'b1, 64'h2, 1'b1);
        apply_subset(1'b0, 64'h8000_0000_0000_000C, 1'b0);

        // zero states: every result is empty
        configure(DIR_IMAGE, 7'd0);
        apply_subset(1'b0, '1, 1'b1);

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            configure(1'(p % 2), phase_count(p));
            no_idle = (p == 4);
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                if ($urandom_range(99) < 30)
                    load_entry(1'($urandom_range(1)), 6'($urandom_range(63)),
                               6'($urandom_range(63)));
                else
                    apply_subset(1'($urandom_range(1)), random_subset(),
                                 1'($urandom_range(1)));
            end
            no_idle = 1'b0;
        end

        drain_results();
        $display("Sent %0d load words and %0d apply words over %0d register settings",
                 loads_sent, applies_sent, settings_done);
        $display("Compared %0d results in image and preimage mode, state counts 0 to 127",
                 compared);
        if (outstanding != 0)
            $display("%0t: %0d expected results never arrived", $time, outstanding);
        if (mismatches == 0 && outstanding == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
